// ===== hdl/tcgr_pkg.sv =====
// Shared types and constants for the text console glyph renderer.
// Depends on nothing; every other file but tcgr_ram takes names from here by scope.
package tcgr_pkg;

    // Font store layout: each glyph occupies a fixed block of rows.
    localparam int BYTES_PER_GLYPH = 16;
    localparam int ROW_ADDR_W      = 4;

    localparam logic [7:0]  NEWLINE_CODE   = 8'd10;

    // Configuration register reset values.
    localparam logic [31:0] DRAW_COLOR_RST = 32'h00FF_FFFF;
    localparam logic [3:0]  FONT_SCALE_RST = 4'd1;
    localparam logic [12:0] SCR_WIDTH_RST  = 13'd640;
    localparam logic [12:0] SCR_HEIGHT_RST = 13'd480;

    // Configuration register indexes.
    localparam logic [1:0] CFG_DRAW_COLOR  = 2'd0;
    localparam logic [1:0] CFG_FONT_SCALE  = 2'd1;
    localparam logic [1:0] CFG_SCR_WIDTH   = 2'd2;
    localparam logic [1:0] CFG_SCR_HEIGHT  = 2'd3;

    typedef enum logic [1:0] {
        CMD_PUT_CHAR   = 2'd0,
        CMD_SET_CURSOR = 2'd1,
        CMD_LOAD_FONT  = 2'd2,
        CMD_NOP        = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SET_CLAMP,
        ST_CHAR,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [7:0]  char_code;
        logic [9:0]  cell_column;
        logic [9:0]  cell_row;
        logic [11:0] font_address;
        logic [7:0]  font_byte;
    } t_in;

    typedef struct packed {
        logic [23:0] pixel_index;
        logic [7:0]  pixel_mask;
        logic [31:0] pixel_color;
        logic        last;
    } t_out;

    // Controller to datapath.
    typedef struct packed {
        logic load_item;
        logic font_we;
        logic set_mul;
        logic wrap;
        logic set_cursor;
        logic newline;
        logic glyph_start;
        logic row_load;
    } t_dp_cmd;

    // Datapath to controller.
    typedef struct packed {
        t_cmd command;
        logic is_newline;
        logic out_space;
        logic last_row;
    } t_dp_status;

endpackage

// ===== hdl/tcgr_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/tcgr_ctrl.sv =====
// Sequencing state machine of the glyph renderer.
// Depends on tcgr_pkg (state, command and status types).
module tcgr_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  tcgr_pkg::t_dp_status i_status,
    output tcgr_pkg::t_dp_cmd    o_cmd
);

    tcgr_pkg::t_state r_state;
    tcgr_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tcgr_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tcgr_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = tcgr_pkg::ST_DECODE;
                end
            end
            tcgr_pkg::ST_DECODE: begin
                case (i_status.command)
                    tcgr_pkg::CMD_PUT_CHAR:   n_state = tcgr_pkg::ST_CHAR;
                    tcgr_pkg::CMD_SET_CURSOR: n_state = tcgr_pkg::ST_SET_CLAMP;
                    default:                  n_state = tcgr_pkg::ST_IDLE;
                endcase
            end
            tcgr_pkg::ST_SET_CLAMP: n_state = tcgr_pkg::ST_IDLE;
            tcgr_pkg::ST_CHAR: begin
                n_state = i_status.is_newline ? tcgr_pkg::ST_IDLE : tcgr_pkg::ST_EMIT;
            end
            tcgr_pkg::ST_EMIT: begin
                if (i_status.out_space && i_status.last_row) begin
                    n_state = tcgr_pkg::ST_IDLE;
                end
            end
            default: n_state = tcgr_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            tcgr_pkg::ST_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            tcgr_pkg::ST_DECODE: begin
                o_cmd.font_we = (i_status.command == tcgr_pkg::CMD_LOAD_FONT);
                o_cmd.set_mul = (i_status.command == tcgr_pkg::CMD_SET_CURSOR);
                o_cmd.wrap    = (i_status.command == tcgr_pkg::CMD_PUT_CHAR);
            end
            tcgr_pkg::ST_SET_CLAMP: o_cmd.set_cursor = 1'b1;
            tcgr_pkg::ST_CHAR: begin
                o_cmd.newline     = i_status.is_newline;
                o_cmd.glyph_start = !i_status.is_newline;
            end
            tcgr_pkg::ST_EMIT: o_cmd.row_load = i_status.out_space;
            default: o_cmd = '0;
        endcase
    end

endmodule

// ===== hdl/tcgr_dp.sv =====
// Datapath of the glyph renderer: config registers, cursor, row address
// generation, mask logic and the output register. Depends on tcgr_pkg.
module tcgr_dp #(
    parameter int GLYPH_COUNT   = 256,
    parameter int GLYPH_ROWS    = 16,
    parameter int MAX_DIMENSION = 4096,
    parameter int AW            = $clog2(GLYPH_COUNT * tcgr_pkg::BYTES_PER_GLYPH)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tcgr_pkg::t_dp_cmd    i_cmd,
    output tcgr_pkg::t_dp_status o_status,
    input  tcgr_pkg::t_in        i_in_data,
    input  logic                 i_cfg_valid,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output tcgr_pkg::t_out       o_out_data,
    output logic                 o_ram_we,
    output logic [AW-1:0]        o_ram_waddr,
    output logic [7:0]           o_ram_wdata,
    output logic                 o_ram_re,
    output logic [AW-1:0]        o_ram_raddr,
    input  logic [7:0]           i_ram_rdata
);

    localparam int STORE_SIZE = GLYPH_COUNT * tcgr_pkg::BYTES_PER_GLYPH;
    localparam int RAW        = tcgr_pkg::ROW_ADDR_W;
    localparam int GW         = AW - RAW;
    localparam int RW         = $clog2(GLYPH_ROWS);

    function automatic logic signed [13:0] sat14(input logic signed [17:0] v);
        logic signed [13:0] res;
        if (v > 18'sd8191) begin
            res = 14'sd8191;
        end else if (v < -18'sd8192) begin
            res = -14'sd8192;
        end else begin
            res = v[13:0];
        end
        return res;
    endfunction

    tcgr_pkg::t_in      r_item;
    logic [31:0]        r_color;
    logic [3:0]         r_scale;
    logic [12:0]        r_width;
    logic [12:0]        r_height;
    logic signed [13:0] r_cx;
    logic signed [13:0] r_cy;
    logic [16:0]        r_px;
    logic [16:0]        r_py;
    logic [23:0]        r_row_pix;
    logic signed [14:0] r_row_y;
    logic [7:0]         r_col_mask;
    logic [RW-1:0]      r_row_cnt;
    logic               r_out_valid;
    tcgr_pkg::t_out     r_out;

    logic [6:0]         w_adv;
    logic [6:0]         w_step;
    logic [12:0]        w_w;
    logic [12:0]        w_h;
    logic signed [14:0] w_w_s;
    logic signed [14:0] w_h_s;
    logic signed [14:0] w_cx_s;
    logic signed [17:0] w_cx18;
    logic signed [17:0] w_cy18;
    logic signed [17:0] w_adv18;
    logic signed [17:0] w_step18;
    logic               w_wrap;
    logic signed [17:0] w_px_c;
    logic signed [17:0] w_py_c;
    logic signed [27:0] w_base_prod;
    logic [23:0]        w_row_base;
    logic [7:0]         w_col_mask;
    logic               w_row_ok;
    logic [8:0]         w_ch9;
    logic [8:0]         w_chmod;
    logic [GW-1:0]      w_glyph;
    logic [RW-1:0]      w_next_cnt;
    logic [RAW-1:0]     w_rd_row;
    logic               w_out_space;

    // Cell geometry and clipped frame size.
    assign w_adv    = 7'({3'b000, r_scale} << 2) + {3'b000, r_scale};
    assign w_step   = {r_scale, 3'b000};
    assign w_w      = (r_width > 13'(MAX_DIMENSION)) ? 13'(MAX_DIMENSION) : r_width;
    assign w_h      = (r_height > 13'(MAX_DIMENSION)) ? 13'(MAX_DIMENSION) : r_height;
    assign w_w_s    = $signed({2'b00, w_w});
    assign w_h_s    = $signed({2'b00, w_h});
    assign w_cx_s   = $signed({r_cx[13], r_cx});
    assign w_cx18   = $signed({{4{r_cx[13]}}, r_cx});
    assign w_cy18   = $signed({{4{r_cy[13]}}, r_cy});
    assign w_adv18  = $signed({11'd0, w_adv});
    assign w_step18 = $signed({11'd0, w_step});

    assign w_wrap = (w_cx_s + $signed({8'd0, w_adv})) >= w_w_s;

    // Clamp the cell position to the frame, then step one cell back.
    assign w_px_c = ({1'b0, r_px} >= {5'd0, w_w}) ?
                    ($signed({5'd0, w_w}) - w_adv18) : $signed({1'b0, r_px});
    assign w_py_c = ({1'b0, r_py} >= {5'd0, w_h}) ?
                    ($signed({5'd0, w_h}) - w_step18) : $signed({1'b0, r_py});

    // Linear index of the glyph's top-left pixel, wrapped to 24 bits.
    assign w_base_prod = $signed(r_cy) * $signed({1'b0, w_w});
    assign w_row_base  = w_base_prod[23:0] + {{10{r_cx[13]}}, r_cx};

    always_comb begin
        logic signed [14:0] px;
        for (int j = 0; j < 8; j++) begin
            px = w_cx_s + $signed(15'(j));
            w_col_mask[7-j] = (px >= 15'sd0) && (px < w_w_s);
        end
    end

    assign w_row_ok = (r_row_y >= 15'sd0) && (r_row_y < w_h_s);

    // Glyph select wraps modulo the glyph count.
    assign w_ch9      = {1'b0, r_item.char_code};
    assign w_chmod    = (w_ch9 >= 9'(GLYPH_COUNT)) ? (w_ch9 - 9'(GLYPH_COUNT)) : w_ch9;
    assign w_glyph    = w_chmod[GW-1:0];
    assign w_next_cnt = r_row_cnt + 1'b1;
    assign w_rd_row   = i_cmd.glyph_start ? '0 : RAW'(w_next_cnt);

    assign o_ram_we    = i_cmd.font_we && ({1'b0, r_item.font_address} < 13'(STORE_SIZE));
    assign o_ram_waddr = r_item.font_address[AW-1:0];
    assign o_ram_wdata = r_item.font_byte;
    assign o_ram_re    = i_cmd.glyph_start || i_cmd.row_load;
    assign o_ram_raddr = {w_glyph, w_rd_row};

    assign w_out_space = !r_out_valid || i_out_ready;

    assign o_status.command    = tcgr_pkg::t_cmd'(r_item.command);
    assign o_status.is_newline = (r_item.char_code == tcgr_pkg::NEWLINE_CODE);
    assign o_status.out_space  = w_out_space;
    assign o_status.last_row   = (r_row_cnt == RW'(GLYPH_ROWS - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_item <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color  <= tcgr_pkg::DRAW_COLOR_RST;
            r_scale  <= tcgr_pkg::FONT_SCALE_RST;
            r_width  <= tcgr_pkg::SCR_WIDTH_RST;
            r_height <= tcgr_pkg::SCR_HEIGHT_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tcgr_pkg::CFG_DRAW_COLOR: r_color  <= i_cfg_data;
                tcgr_pkg::CFG_FONT_SCALE: r_scale  <= i_cfg_data[3:0];
                tcgr_pkg::CFG_SCR_WIDTH:  r_width  <= i_cfg_data[12:0];
                tcgr_pkg::CFG_SCR_HEIGHT: r_height <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cx <= '0;
            r_cy <= '0;
        end else if (i_cmd.wrap) begin
            if (w_wrap) begin
                r_cy <= sat14(w_cy18 + w_step18);
                r_cx <= '0;
            end
        end else if (i_cmd.set_cursor) begin
            r_cx <= sat14(w_px_c - w_adv18);
            r_cy <= sat14(w_py_c - w_step18);
        end else if (i_cmd.newline) begin
            r_cy <= sat14(w_cy18 + w_step18);
            r_cx <= 14'sd1;
        end else if (i_cmd.glyph_start) begin
            r_cx <= sat14(w_cx18 + w_adv18);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.set_mul) begin
            r_px <= {7'd0, r_item.cell_column} * {10'd0, w_adv};
            r_py <= {7'd0, r_item.cell_row} * {10'd0, w_step};
        end
    end

    // Row walker: capture the glyph origin, then advance one row per transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt <= '0;
        end else if (i_cmd.glyph_start) begin
            r_row_cnt <= '0;
        end else if (i_cmd.row_load) begin
            r_row_cnt <= w_next_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.glyph_start) begin
            r_row_pix  <= w_row_base;
            r_row_y    <= w_cx_s - w_cx_s + $signed({r_cy[13], r_cy});
            r_col_mask <= w_col_mask;
        end else if (i_cmd.row_load) begin
            r_row_pix <= r_row_pix + {11'd0, w_w};
            r_row_y   <= r_row_y + 15'sd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.row_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.row_load) begin
            r_out.pixel_index <= r_row_pix;
            r_out.pixel_mask  <= i_ram_rdata & r_col_mask & {8{w_row_ok}};
            r_out.pixel_color <= r_color;
            r_out.last        <= (r_row_cnt == RW'(GLYPH_ROWS - 1));
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/text_console_glyph_renderer_top.sv =====
// Text console glyph renderer: draws 8-pixel-wide glyphs into a 32-bit frame.
// A glyph's first row write is registered through the decode, character and emit
// states after the transfer in; then one row per cycle from the font store read
// port while the output accepts, GLYPH_ROWS rows per character.
// Reset (synchronous, active low) clears the cursor and loads the register
// defaults; the font store is not cleared. Depends on tcgr_pkg, tcgr_ctrl,
// tcgr_dp and tcgr_ram.
module text_console_glyph_renderer_top #(
    parameter int GLYPH_COUNT   = 256,
    parameter int GLYPH_ROWS    = 16,
    parameter int MAX_DIMENSION = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  tcgr_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output tcgr_pkg::t_out o_out_data,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data
);

    localparam int STORE_SIZE = GLYPH_COUNT * tcgr_pkg::BYTES_PER_GLYPH;
    localparam int AW         = $clog2(STORE_SIZE);

    tcgr_pkg::t_dp_cmd    w_cmd;
    tcgr_pkg::t_dp_status w_status;
    logic                 w_ram_we;
    logic [AW-1:0]        w_ram_waddr;
    logic [7:0]           w_ram_wdata;
    logic                 w_ram_re;
    logic [AW-1:0]        w_ram_raddr;
    logic [7:0]           w_ram_rdata;

    assign o_cfg_ready = 1'b1;

    tcgr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    tcgr_dp #(
        .GLYPH_COUNT   (GLYPH_COUNT),
        .GLYPH_ROWS    (GLYPH_ROWS),
        .MAX_DIMENSION (MAX_DIMENSION),
        .AW            (AW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_in_data   (i_in_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_re    (w_ram_re),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    tcgr_ram #(
        .WIDTH (8),
        .DEPTH (STORE_SIZE)
    ) u_font_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (w_ram_re),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

endmodule

// ===== hdl/tcgr_checker.sv =====
// Port-level checks for the glyph renderer, bound to the top level.
// Depends on tcgr_pkg and text_console_glyph_renderer_top.
module tcgr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input tcgr_pkg::t_in  i_in_data,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input tcgr_pkg::t_out o_out_data
);

    // A stalled row write holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("row write changed while stalled");

    // One item at a time: ready drops right after a transfer in.
    a_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while previous item in flight");

    // Font loads and no-ops go from decode straight back to idle and ready.
    a_short_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready &&
         (i_in_data.command == tcgr_pkg::CMD_LOAD_FONT ||
          i_in_data.command == tcgr_pkg::CMD_NOP)) |=> ##1 o_in_ready)
        else $error("short command did not return to ready");

    // While a glyph still has rows to send, no new item is taken.
    a_glyph_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.last) |-> !o_in_ready)
        else $error("ready while glyph rows remain");

endmodule

bind text_console_glyph_renderer_top tcgr_checker u_tcgr_checker (.*);

// ===== verif/glyph_row_checker.sv =====
// Scoreboard for the text console glyph renderer: mirrors registers, font store and
// cursor from observed transfers and checks every row write in order.
// Depends on tcgr_pkg.
`timescale 1ns / 100ps
module glyph_row_checker #(
    parameter int GLYPH_COUNT   = 256,
    parameter int GLYPH_ROWS    = 16,
    parameter int MAX_DIMENSION = 4096
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_ready,
    input  tcgr_pkg::t_in  i_in_data,
    input  logic           i_out_valid,
    input  logic           i_out_ready,
    input  tcgr_pkg::t_out i_out_data,
    input  logic           i_cfg_valid,
    input  logic           i_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [31:0]    i_cfg_data,
    output int             o_fail_count,
    output int             o_pending
);

    localparam int STORE_BYTES = GLYPH_COUNT * tcgr_pkg::BYTES_PER_GLYPH;
    localparam int CURSOR_MIN  = -8192;
    localparam int CURSOR_MAX  = 8191;
    localparam int REPORT_MAX  = 10;

    logic [31:0]    draw_color;
    logic [3:0]     font_scale;
    logic [12:0]    screen_width;
    logic [12:0]    screen_height;
    logic [7:0]     font_bytes [STORE_BYTES];
    int             cur_x;
    int             cur_y;
    tcgr_pkg::t_out row_writes_q [$];
    int             fail_count = 0;

    function automatic int sat_cursor(input int v);
        if (v < CURSOR_MIN) return CURSOR_MIN;
        if (v > CURSOR_MAX) return CURSOR_MAX;
        return v;
    endfunction

    function automatic int frame_limit(input logic [12:0] v);
        return (int'(v) > MAX_DIMENSION) ? MAX_DIMENSION : int'(v);
    endfunction

    // Update cursor and font state and queue the row writes one command causes.
    task automatic apply_command(input tcgr_pkg::t_in item);
        int             adv;
        int             line_step;
        int             w;
        int             h;
        int             px;
        int             py;
        int             base;
        logic [7:0]     bits;
        tcgr_pkg::t_out wr;
        adv       = 5 * int'(font_scale);
        line_step = 8 * int'(font_scale);
        w         = frame_limit(screen_width);
        h         = frame_limit(screen_height);
        case (tcgr_pkg::t_cmd'(item.command))
            tcgr_pkg::CMD_LOAD_FONT: begin
                if (int'(item.font_address) < STORE_BYTES)
                    font_bytes[item.font_address] = item.font_byte;
            end
            tcgr_pkg::CMD_SET_CURSOR: begin
                px = int'(item.cell_column) * adv;
                py = int'(item.cell_row) * line_step;
                if (px >= w) px = w - adv;
                if (py >= h) py = h - line_step;
                cur_x = sat_cursor(px - adv);
                cur_y = sat_cursor(py - line_step);
            end
            tcgr_pkg::CMD_PUT_CHAR: begin
                if (cur_x + adv >= w) begin
                    cur_y = sat_cursor(cur_y + line_step);
                    cur_x = 0;
                end
                if (item.char_code == tcgr_pkg::NEWLINE_CODE) begin
                    cur_y = sat_cursor(cur_y + line_step);
                    cur_x = 1;
                end else begin
                    base = (int'(item.char_code) % GLYPH_COUNT) * tcgr_pkg::BYTES_PER_GLYPH;
                    for (int row = 0; row < GLYPH_ROWS; row++) begin
                        py            = cur_y + row;
                        bits          = font_bytes[(base + row) % STORE_BYTES];
                        wr.pixel_mask = '0;
                        // drop pixels that fall outside the frame
                        if (py >= 0 && py < h) begin
                            for (int j = 0; j < 8; j++) begin
                                px = cur_x + j;
                                if (bits[7 - j] && px >= 0 && px < w)
                                    wr.pixel_mask[7 - j] = 1'b1;
                            end
                        end
                        wr.pixel_index = 24'(py * w + cur_x);
                        wr.pixel_color = draw_color;
                        wr.last        = (row == GLYPH_ROWS - 1);
                        row_writes_q.push_back(wr);
                    end
                    cur_x = sat_cursor(cur_x + adv);
                end
            end
            default: ;
        endcase
    endtask

    task automatic check_row_write(input tcgr_pkg::t_out got);
        tcgr_pkg::t_out want;
        if (row_writes_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("%0t: unexpected row write: index %h mask %h color %h last %b",
                         $realtime, got.pixel_index, got.pixel_mask, got.pixel_color,
                         got.last);
        end else begin
            want = row_writes_q.pop_front();
            if (got.pixel_index !== want.pixel_index || got.pixel_mask !== want.pixel_mask ||
                got.pixel_color !== want.pixel_color || got.last !== want.last) begin
                fail_count++;
                if (fail_count <= REPORT_MAX)
                    $display({"%0t: row write mismatch: expected index %h mask %h color %h ",
                              "last %b, got index %h mask %h color %h last %b"},
                             $realtime, want.pixel_index, want.pixel_mask, want.pixel_color,
                             want.last, got.pixel_index, got.pixel_mask, got.pixel_color,
                             got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            draw_color    = tcgr_pkg::DRAW_COLOR_RST;
            font_scale    = tcgr_pkg::FONT_SCALE_RST;
            screen_width  = tcgr_pkg::SCR_WIDTH_RST;
            screen_height = tcgr_pkg::SCR_HEIGHT_RST;
            cur_x         = 0;
            cur_y         = 0;
            row_writes_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) check_row_write(i_out_data);
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    tcgr_pkg::CFG_DRAW_COLOR: draw_color    = i_cfg_data;
                    tcgr_pkg::CFG_FONT_SCALE: font_scale    = i_cfg_data[3:0];
                    tcgr_pkg::CFG_SCR_WIDTH:  screen_width  = i_cfg_data[12:0];
                    tcgr_pkg::CFG_SCR_HEIGHT: screen_height = i_cfg_data[12:0];
                    default: ;
                endcase
            end
            if (i_in_valid && i_in_ready) apply_command(i_in_data);
        end
        o_pending    = row_writes_q.size();
        o_fail_count = fail_count;
    end

endmodule

// ===== verif/text_console_glyph_renderer_top_test.sv =====
// Testbench top for the text console glyph renderer: drives commands, register
// writes and output backpressure, and gives the verdict.
// Depends on tcgr_pkg, text_console_glyph_renderer_top and glyph_row_checker.
`timescale 1ns / 100ps
module text_console_glyph_renderer_top_test;

    localparam int GLYPH_COUNT   = 256;
    localparam int GLYPH_ROWS    = 16;
    localparam int MAX_DIMENSION = 4096;
    localparam int CLK_PERIOD    = 12;
    localparam int RESET_CYCLES  = 10;
    localparam int QUIET_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 22;
    localparam int BURST_PHASE   = 3;
    localparam int NEWLINE_BURST = 72;

    typedef enum int {FILL_RANDOM, FILL_SOLID, FILL_STRIPE} t_fill;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           in_valid  = 1'b0;
    logic           in_ready;
    tcgr_pkg::t_in  in_data   = '0;
    logic           out_valid;
    logic           out_ready = 1'b0;
    tcgr_pkg::t_out out_data;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [1:0]     cfg_index = tcgr_pkg::CFG_DRAW_COLOR;
    logic [31:0]    cfg_data  = '0;

    int          fail_count;
    int          pending;
    int          in_gap_pct    = 25;
    int          out_stall_pct = 15;
    int          stall_left    = 0;
    int          quiet_cycles  = 0;
    bit          glyph_loaded [GLYPH_COUNT];
    logic [7:0]  ready_glyphs [$];

    text_console_glyph_renderer_top #(
        .GLYPH_COUNT   (GLYPH_COUNT),
        .GLYPH_ROWS    (GLYPH_ROWS),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    glyph_row_checker #(
        .GLYPH_COUNT   (GLYPH_COUNT),
        .GLYPH_ROWS    (GLYPH_ROWS),
        .MAX_DIMENSION (MAX_DIMENSION)
    ) row_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Output backpressure: at random, hold ready low for a burst of random length.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(99) < out_stall_pct) begin
            out_ready  <= 1'b0;
            stall_left <= $urandom_range(16);
        end else begin
            out_ready <= 1'b1;
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("text_console_glyph_renderer_top test failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic tcgr_pkg::t_in any_fields(input tcgr_pkg::t_cmd cmd);
        tcgr_pkg::t_in item;
        item.command      = cmd;
        item.char_code    = 8'($urandom_range(255));
        item.cell_column  = 10'($urandom_range(1023));
        item.cell_row     = 10'($urandom_range(1023));
        item.font_address = 12'($urandom_range(4095));
        item.font_byte    = 8'($urandom_range(255));
        return item;
    endfunction

    function automatic logic [9:0] pick_cell();
        case ($urandom_range(3))
            0:       return 10'd0;
            1:       return 10'd1023;
            default: return 10'($urandom_range(100));
        endcase
    endfunction

    // Hold valid until the transfer; keep it high into the next item unless a gap is drawn.
    task automatic send_cmd(input tcgr_pkg::t_in item);
        int gap;
        gap = 0;
        if ($urandom_range(99) < in_gap_pct) gap = $urandom_range(17, 1);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic put_char(input logic [7:0] code);
        tcgr_pkg::t_in item;
        item           = any_fields(tcgr_pkg::CMD_PUT_CHAR);
        item.char_code = code;
        send_cmd(item);
    endtask

    task automatic set_cursor(input logic [9:0] col, input logic [9:0] row);
        tcgr_pkg::t_in item;
        item             = any_fields(tcgr_pkg::CMD_SET_CURSOR);
        item.cell_column = col;
        item.cell_row    = row;
        send_cmd(item);
    endtask

    task automatic load_byte(input logic [11:0] addr, input logic [7:0] value);
        tcgr_pkg::t_in item;
        item              = any_fields(tcgr_pkg::CMD_LOAD_FONT);
        item.font_address = addr;
        item.font_byte    = value;
        send_cmd(item);
    endtask

    task automatic load_glyph(input logic [7:0] code, input t_fill fill);
        logic [7:0] value;
        for (int row = 0; row < GLYPH_ROWS; row++) begin
            case (fill)
                FILL_SOLID:  value = 8'hFF;
                FILL_STRIPE: value = row[0] ? 8'h55 : 8'hAA;
                default:     value = 8'($urandom_range(255));
            endcase
            load_byte({code, 4'(row)}, value);
        end
        if (!glyph_loaded[code]) begin
            glyph_loaded[code] = 1'b1;
            ready_glyphs.push_back(code);
        end
    endtask

    // Lower valid, wait out every row write and the block's tail before a register write.
    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic configure(input int phase);
        logic [31:0] color;
        logic [3:0]  scale;
        logic [12:0] width;
        logic [12:0] height;
        color  = $urandom;
        scale  = 4'($urandom_range(8, 1));
        width  = 13'($urandom_range(MAX_DIMENSION, 8));
        height = 13'($urandom_range(MAX_DIMENSION, 8));
        case (phase)
            0: begin
                color  = 32'h0000_0000;
                width  = 13'd8;
                height = 13'd8;
            end
            1: begin
                color  = 32'hFFFF_FFFF;
                scale  = 4'd8;
                width  = 13'(MAX_DIMENSION);
                height = 13'(MAX_DIMENSION);
            end
            2: begin
                scale  = 4'd0;
                width  = 13'h1FFF;
                height = 13'h1FFF;
            end
            BURST_PHASE: begin
                scale  = 4'hF;
                width  = 13'($urandom_range(200, 80));
                height = 13'h1FFF;
            end
            default: begin
                // half the time a narrow frame so lines wrap often
                if ($urandom_range(1)) width = 13'($urandom_range(60, 8));
            end
        endcase
        write_reg(tcgr_pkg::CFG_DRAW_COLOR, color);
        write_reg(tcgr_pkg::CFG_FONT_SCALE, 32'(scale));
        write_reg(tcgr_pkg::CFG_SCR_WIDTH, 32'(width));
        write_reg(tcgr_pkg::CFG_SCR_HEIGHT, 32'(height));
    endtask

    task automatic run_random(input int count);
        int            made;
        int            pick;
        tcgr_pkg::t_in item;
        made = 0;
        while (made < count) begin
            pick = $urandom_range(99);
            if (pick < 5) begin
                load_glyph(8'($urandom_range(255)), FILL_RANDOM);
                made += GLYPH_ROWS;
            end else if (pick < 10) begin
                // stray single-byte load anywhere in the store
                load_byte(12'($urandom_range(4095)), 8'($urandom_range(255)));
                made++;
            end else if (pick < 18) begin
                set_cursor(pick_cell(), pick_cell());
                made++;
            end else if (pick < 25) begin
                put_char(tcgr_pkg::NEWLINE_CODE);
                made++;
            end else if (pick < 28) begin
                item = any_fields(tcgr_pkg::CMD_NOP);
                send_cmd(item);
            end else begin
                put_char(ready_glyphs[$urandom_range(ready_glyphs.size() - 1)]);
                made++;
            end
        end
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        load_glyph(8'h00, FILL_SOLID);
        load_glyph(8'hFF, FILL_STRIPE);
        load_glyph(8'h41, FILL_RANDOM);

        // Reset defaults: 640x480, scale 1.
        put_char(8'h41);
        put_char(8'h00);
        put_char(8'hFF);
        put_char(tcgr_pkg::NEWLINE_CODE);
        send_cmd(any_fields(tcgr_pkg::CMD_NOP));
        set_cursor(10'd0, 10'd0);            // cursor lands left of and above the frame
        put_char(8'h00);
        set_cursor(10'd1023, 10'd1023);      // clamp to the last cell
        put_char(8'hFF);
        put_char(8'h00);                     // wraps; rows run past the bottom
        put_char(tcgr_pkg::NEWLINE_CODE);
        put_char(8'h00);                     // wholly below the frame
        set_cursor(10'd127, 10'd10);
        put_char(8'hFF);
        put_char(8'h00);
        load_byte(12'h410, 8'h81);           // rewrite a row, then draw it at once
        put_char(8'h41);
        set_cursor(10'd2, 10'd1);
        put_char(8'h41);
        put_char(tcgr_pkg::NEWLINE_CODE);
        put_char(tcgr_pkg::NEWLINE_CODE);
        put_char(8'hFF);

        for (int phase = 0; phase < PHASES; phase++) begin
            // pick the idling first so a running stall burst ends inside the drain
            if (phase == PHASES - 1) begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end else if (phase % 3 == 2) begin
                in_gap_pct    = 0;
                out_stall_pct = 0;
            end else begin
                in_gap_pct    = $urandom_range(40, 5);
                out_stall_pct = $urandom_range(30, 5);
            end
            drain();
            configure(phase);
            // drive the cursor to the bottom limit
            if (phase == BURST_PHASE) repeat (NEWLINE_BURST) put_char(tcgr_pkg::NEWLINE_CODE);
            run_random(PHASE_ITEMS);
        end
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("text_console_glyph_renderer_top test passed");
        end else begin
            $display("text_console_glyph_renderer_top test failed");
        end
        $finish;
    end

endmodule
